// ----- hdl/csmv_pkg.sv -----
// ----------------------------------------------------------------------------
// csmv_pkg
// Shared types and constants for the scaled CSR sparse matrix-vector block.
// ----------------------------------------------------------------------------
package csmv_pkg;

  // field widths
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned INDEX_W     = 12;
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned ROW_W       = 16;
  localparam int unsigned ACC_W       = 64;
  localparam int unsigned IN_TDATA_W  = 48;
  localparam int unsigned OUT_TDATA_W = 48;
  localparam int unsigned CFG_IDX_W   = 2;

  // default depth of the local x store
  localparam int unsigned X_DEPTH_DEF = 4096;

  // item kinds carried in tuser
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_X  = 2'd0,
    MODE_NONZERO = 2'd1,
    MODE_ROW_END = 2'd2
  } mode_e;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 2'd1;

  // register reset values, Q16.16
  localparam logic signed [DATA_W-1:0] ALPHA_RESET = 32'sh0001_0000;
  localparam logic signed [DATA_W-1:0] BETA_RESET  = 32'sh0000_0000;

endpackage

// ----- hdl/csmv_ram.sv -----
// ----------------------------------------------------------------------------
// csmv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csmv_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/csr_sparse_matvec_axpby_top.sv -----
// ----------------------------------------------------------------------------
// csr_sparse_matvec_axpby_top
// Streaming y = alpha*A*x + beta*y for a CSR matrix, Q16.16 in and out.
// ----------------------------------------------------------------------------
// The block takes one item per clock while not stalled and returns a registered
// result for each row-end item. A load item writes one x entry into the local x
// RAM; a nonzero item reads its column from that RAM, multiplies and adds into
// a saturating Q32.32 row sum; a row-end item carries the old y and produces
// alpha*sum + beta*y_old, rounded and saturated to Q16.16, together with the
// count of rows finished since the last x load. The latency is set by the RAM
// read, one 32x32 multiplier for nonzero and beta products, and two further
// 32x32 partial products for alpha times the 64-bit row sum. The whole pipeline
// advances together and holds when a result waits at the output, so s_axis_tready
// follows m_axis_tready while a result is pending. Entries of the x RAM are
// undefined until loaded. The user must write alpha and beta through the
// configuration port only while no item is in flight; the block does not enforce it.
module csr_sparse_matvec_axpby_top #(
  parameter int unsigned X_DEPTH = csmv_pkg::X_DEPTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input stream
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata from bit 0: index[11:0], value[43:12], zero[47:44]
  input  logic [csmv_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // tuser from bit 0: mode[1:0]
  input  logic [csmv_pkg::MODE_W-1:0]           s_axis_tuser,
  // result stream
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // tdata from bit 0: y_value[31:0], row_number[47:32]
  output logic [csmv_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // configuration writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [csmv_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [csmv_pkg::DATA_W-1:0]           cfg_data_i
);

  localparam int unsigned AW = $clog2(X_DEPTH);

  localparam logic signed [csmv_pkg::ACC_W-1:0] ACC_MAX = {1'b0, {(csmv_pkg::ACC_W-1){1'b1}}};
  localparam logic signed [csmv_pkg::ACC_W-1:0] ACC_MIN = {1'b1, {(csmv_pkg::ACC_W-1){1'b0}}};
  localparam logic signed [csmv_pkg::DATA_W-1:0] Y_MAX  = {1'b0, {(csmv_pkg::DATA_W-1){1'b1}}};
  localparam logic signed [csmv_pkg::DATA_W-1:0] Y_MIN  = {1'b1, {(csmv_pkg::DATA_W-1){1'b0}}};

  // saturating signed 64-bit add
  function automatic logic signed [csmv_pkg::ACC_W-1:0] sat_add(
    input logic signed [csmv_pkg::ACC_W-1:0] a,
    input logic signed [csmv_pkg::ACC_W-1:0] b
  );
    logic signed [csmv_pkg::ACC_W-1:0] s;
    s = a + b;
    if ((a[csmv_pkg::ACC_W-1] == b[csmv_pkg::ACC_W-1]) &&
        (s[csmv_pkg::ACC_W-1] != a[csmv_pkg::ACC_W-1])) begin
      s = a[csmv_pkg::ACC_W-1] ? ACC_MIN : ACC_MAX;
    end
    return s;
  endfunction

  // configuration registers
  logic signed [csmv_pkg::DATA_W-1:0] alpha_q, beta_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= csmv_pkg::ALPHA_RESET;
      beta_q  <= csmv_pkg::BETA_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        csmv_pkg::CFG_ALPHA: alpha_q <= cfg_data_i;
        csmv_pkg::CFG_BETA:  beta_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline advance and input handshake
  logic adv, in_acc;
  logic m_valid_q;

  assign adv           = !m_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_acc        = s_axis_tvalid && adv;

  // input field unpacking
  csmv_pkg::mode_e                    in_mode;
  logic [csmv_pkg::INDEX_W-1:0]       in_index;
  logic signed [csmv_pkg::DATA_W-1:0] in_value;
  logic                               in_range;

  assign in_mode  = csmv_pkg::mode_e'(s_axis_tuser);
  assign in_index = s_axis_tdata[csmv_pkg::INDEX_W-1:0];
  assign in_value = s_axis_tdata[csmv_pkg::INDEX_W +: csmv_pkg::DATA_W];
  assign in_range = {20'd0, in_index} < 32'(X_DEPTH);

  // x store
  logic                        x_we, x_re;
  logic [AW-1:0]               x_addr;
  logic [csmv_pkg::DATA_W-1:0] x_rdata;

  assign x_we   = in_acc && (in_mode == csmv_pkg::MODE_LOAD_X) && in_range;
  assign x_re   = in_acc && (in_mode == csmv_pkg::MODE_NONZERO);
  assign x_addr = AW'(in_index);

  csmv_ram #(
    .WIDTH (csmv_pkg::DATA_W),
    .DEPTH (X_DEPTH)
  ) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (x_addr),
    .wdata_i (in_value),
    .re_i    (x_re),
    .raddr_i (x_addr),
    .rdata_o (x_rdata)
  );

  // stage 1: item registered, x read in flight
  logic                               s1_vld_q;
  csmv_pkg::mode_e                    s1_mode_q;
  logic signed [csmv_pkg::DATA_W-1:0] s1_value_q;
  logic                               s1_range_q;

  // stage 2: value*x for a nonzero, beta*y_old for a row end
  logic                               s2_vld_q;
  csmv_pkg::mode_e                    s2_mode_q;
  logic signed [csmv_pkg::ACC_W-1:0]  s2_prod_q;
  logic signed [csmv_pkg::DATA_W-1:0] mul_b_d;
  logic signed [csmv_pkg::ACC_W-1:0]  s2_prod_d;

  always_comb begin
    if (s1_mode_q == csmv_pkg::MODE_ROW_END) begin
      mul_b_d = beta_q;
    end else if (s1_range_q) begin
      mul_b_d = x_rdata;
    end else begin
      mul_b_d = '0;
    end
    s2_prod_d = s1_value_q * mul_b_d;
  end

  // stage 3: row sum, row count, magnitudes for the alpha product
  logic signed [csmv_pkg::ACC_W-1:0]  row_sum_q;
  logic [csmv_pkg::ROW_W-1:0]         row_cnt_q;
  logic                               s3_vld_q;
  logic                               s3_neg_q;
  logic [csmv_pkg::DATA_W-1:0]        s3_ma_q;
  logic [csmv_pkg::ACC_W-1:0]         s3_ms_q;
  logic signed [csmv_pkg::ACC_W-1:0]  s3_t2_q;
  logic [csmv_pkg::ROW_W-1:0]         s3_row_q;
  logic [csmv_pkg::DATA_W-1:0]        ma_d;
  logic [csmv_pkg::ACC_W-1:0]         ms_d;
  logic [csmv_pkg::ROW_W-1:0]         row_next_d;

  assign ma_d = alpha_q[csmv_pkg::DATA_W-1] ? (csmv_pkg::DATA_W'(0) - alpha_q) : alpha_q;
  assign ms_d = row_sum_q[csmv_pkg::ACC_W-1] ? (csmv_pkg::ACC_W'(0) - row_sum_q) : row_sum_q;
  assign row_next_d = row_cnt_q + csmv_pkg::ROW_W'(1);

  // stage 4 and 5: partial products of |alpha| * |sum|
  logic                               s4_vld_q, s5_vld_q;
  logic                               s4_neg_q, s5_neg_q;
  logic [csmv_pkg::DATA_W-1:0]        s4_ma_q;
  logic [csmv_pkg::DATA_W-1:0]        s4_mshi_q;
  logic [csmv_pkg::ACC_W-1:0]         s4_p0_q, s5_p0_q, s5_p1_q;
  logic signed [csmv_pkg::ACC_W-1:0]  s4_t2_q, s5_t2_q;
  logic [csmv_pkg::ROW_W-1:0]         s4_row_q, s5_row_q;

  // stage 6: full product plus rounding half
  logic                               s6_vld_q, s6_neg_q;
  logic [95:0]                        s6_rnd_q;
  logic signed [csmv_pkg::ACC_W-1:0]  s6_t2_q;
  logic [csmv_pkg::ROW_W-1:0]         s6_row_q;

  // stage 7: alpha term back in Q32.32, signed and saturated
  logic                               s7_vld_q;
  logic signed [csmv_pkg::ACC_W-1:0]  s7_t1_q, s7_t2_q;
  logic [csmv_pkg::ROW_W-1:0]         s7_row_q;
  logic                               t1_sat_d;
  logic [csmv_pkg::ACC_W-1:0]         t1_mag_d;
  logic signed [csmv_pkg::ACC_W-1:0]  t1_d;

  assign t1_mag_d = s6_rnd_q[79:16];
  assign t1_sat_d = (|s6_rnd_q[95:80]) || t1_mag_d[csmv_pkg::ACC_W-1];

  always_comb begin
    if (t1_sat_d) begin
      t1_d = s6_neg_q ? ACC_MIN : ACC_MAX;
    end else if (s6_neg_q) begin
      t1_d = csmv_pkg::ACC_W'(0) - t1_mag_d;
    end else begin
      t1_d = t1_mag_d;
    end
  end

  // stage 8: sum of both terms
  logic                               s8_vld_q;
  logic signed [csmv_pkg::ACC_W-1:0]  s8_t_q;
  logic [csmv_pkg::ROW_W-1:0]         s8_row_q;

  // output stage: round to Q16.16, ties away from zero, and saturate
  logic signed [csmv_pkg::ACC_W:0]    rnd_sum_d;
  logic signed [48:0]                 rnd_q16_d;
  logic signed [csmv_pkg::DATA_W-1:0] y_d;
  logic signed [csmv_pkg::DATA_W-1:0] y_q;
  logic [csmv_pkg::ROW_W-1:0]         row_q;

  always_comb begin
    rnd_sum_d = {s8_t_q[csmv_pkg::ACC_W-1], s8_t_q} +
                (s8_t_q[csmv_pkg::ACC_W-1] ? 65'sh7FFF : 65'sh8000);
    rnd_q16_d = rnd_sum_d[csmv_pkg::ACC_W:16];
    if (rnd_q16_d[48:31] == {18{1'b0}} || rnd_q16_d[48:31] == {18{1'b1}}) begin
      y_d = rnd_q16_d[csmv_pkg::DATA_W-1:0];
    end else begin
      y_d = rnd_q16_d[48] ? Y_MIN : Y_MAX;
    end
  end

  // valid bits and accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      s8_vld_q  <= 1'b0;
      m_valid_q <= 1'b0;
      row_sum_q <= '0;
      row_cnt_q <= '0;
    end else if (adv) begin
      s1_vld_q  <= in_acc;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q && (s2_mode_q == csmv_pkg::MODE_ROW_END);
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      s6_vld_q  <= s5_vld_q;
      s7_vld_q  <= s6_vld_q;
      s8_vld_q  <= s7_vld_q;
      m_valid_q <= s8_vld_q;
      if (s2_vld_q) begin
        case (s2_mode_q)
          csmv_pkg::MODE_LOAD_X:  row_cnt_q <= '0;
          csmv_pkg::MODE_NONZERO: row_sum_q <= sat_add(row_sum_q, s2_prod_q);
          csmv_pkg::MODE_ROW_END: begin
            row_sum_q <= '0;
            row_cnt_q <= row_next_d;
          end
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_mode_q  <= in_mode;
      s1_value_q <= in_value;
      s1_range_q <= in_range;

      s2_mode_q  <= s1_mode_q;
      s2_prod_q  <= s2_prod_d;

      s3_neg_q   <= alpha_q[csmv_pkg::DATA_W-1] ^ row_sum_q[csmv_pkg::ACC_W-1];
      s3_ma_q    <= ma_d;
      s3_ms_q    <= ms_d;
      s3_t2_q    <= s2_prod_q;
      s3_row_q   <= row_next_d;

      s4_neg_q   <= s3_neg_q;
      s4_ma_q    <= s3_ma_q;
      s4_mshi_q  <= s3_ms_q[csmv_pkg::ACC_W-1:csmv_pkg::DATA_W];
      s4_p0_q    <= s3_ms_q[csmv_pkg::DATA_W-1:0] * s3_ma_q;
      s4_t2_q    <= s3_t2_q;
      s4_row_q   <= s3_row_q;

      s5_neg_q   <= s4_neg_q;
      s5_p0_q    <= s4_p0_q;
      s5_p1_q    <= s4_mshi_q * s4_ma_q;
      s5_t2_q    <= s4_t2_q;
      s5_row_q   <= s4_row_q;

      s6_neg_q   <= s5_neg_q;
      s6_rnd_q   <= {s5_p1_q, 32'd0} + {32'd0, s5_p0_q} + 96'h8000;
      s6_t2_q    <= s5_t2_q;
      s6_row_q   <= s5_row_q;

      s7_t1_q    <= t1_d;
      s7_t2_q    <= s6_t2_q;
      s7_row_q   <= s6_row_q;

      s8_t_q     <= sat_add(s7_t1_q, s7_t2_q);
      s8_row_q   <= s7_row_q;

      y_q        <= y_d;
      row_q      <= s8_row_q;
    end
  end

  // result stream
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {row_q, y_q};

endmodule

// ----- hdl/csmv_checker.sv -----
// ----------------------------------------------------------------------------
// csmv_checker
// Port-level checks for the sparse matrix-vector block, bound to the top.
// ----------------------------------------------------------------------------
module csmv_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [csmv_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                             cfg_valid_i,
  input logic                             cfg_ready_o
);

  // a stalled result keeps its item
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // input side stalls only while a result is held at the output
  a_ready_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output state");

  // no result shown in the cycle after reset is seen
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid after reset");

  // configuration writes are never refused
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind csr_sparse_matvec_axpby_top csmv_checker u_csmv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_valid_i   (cfg_valid_i),
  .cfg_ready_o   (cfg_ready_o)
);
